// ===== hdl/ssto_pkg.sv =====
// ----------------------------------------------------------------------------
// ssto_pkg: shared types and constants for the shutdown sequencer
// Phase codes, register indexes, input/result item layouts and config set.
// ----------------------------------------------------------------------------
package ssto_pkg;

  // Field widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SNAP_W  = 5;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Snapshot slots available in the vault
  localparam logic [SNAP_W-1:0] SNAP_SLOTS = SNAP_W'(16);

  // Sequence phases
  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_NAS   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_STORE = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RETRY = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE  = 3'd4;

  // Input action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NAS_TIMEOUT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STORAGE_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPORT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VAULT         = 2'd3;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 24;

  typedef struct packed {
    logic              action;
    logic [TIME_W-1:0] now_sec;
    logic              armed;
    logic [SNAP_W-1:0] snap_count_in;
    logic              nas_acked;
    logic              kill_accepted;
    logic              flush_ok;
  } in_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               busy_res;
    logic               kill_done;
    logic               nas_timeout_flag;
    logic               storage_ok;
    logic               retry_used;
    logic               peek_ok;
    logic [SNAP_W-1:0]  snap_count_out;
    logic               nas_flush_req;
    logic               kill_req;
    logic               conceal_req;
    logic               storage_flush_req;
  } res_t;

  typedef struct packed {
    logic [TIME_W-1:0] nas_timeout_sec;
    logic [TIME_W-1:0] storage_delay_sec;
    logic              transport_present;
    logic              vault_present;
  } cfg_t;

endpackage

// ===== hdl/ssto_core.sv =====
// ----------------------------------------------------------------------------
// ssto_core: sequencer state and per-item update
// Holds the phase, status flags and due times; computes one result per item.
// ----------------------------------------------------------------------------
module ssto_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept_i,
  input  ssto_pkg::in_item_t item_i,
  input  ssto_pkg::cfg_t  cfg_i,
  output ssto_pkg::res_t  res_o
);
  import ssto_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               busy_r, busy_nxt;
  logic               kill_done_r, kill_done_nxt;
  logic               nas_to_r, nas_to_nxt;
  logic               stor_ok_r, stor_ok_nxt;
  logic               retry_r, retry_nxt;
  logic [SNAP_W-1:0]  snap_r, snap_nxt;
  logic [TIME_W-1:0]  nas_due_r, nas_due_nxt;
  logic [TIME_W-1:0]  stor_due_r, stor_due_nxt;

  logic nreq, kreq, creq, sreq;
  logic leave_nas;
  logic [TIME_W-1:0] stor_due_new;

  assign stor_due_new = item_i.now_sec + cfg_i.storage_delay_sec;

  // Next state and requests for the current item
  always_comb begin
    phase_nxt     = phase_r;
    busy_nxt      = busy_r;
    kill_done_nxt = kill_done_r;
    nas_to_nxt    = nas_to_r;
    stor_ok_nxt   = stor_ok_r;
    retry_nxt     = retry_r;
    snap_nxt      = snap_r;
    nas_due_nxt   = nas_due_r;
    stor_due_nxt  = stor_due_r;
    nreq          = 1'b0;
    kreq          = 1'b0;
    creq          = 1'b0;
    sreq          = 1'b0;
    leave_nas     = 1'b0;

    if (item_i.action == ACT_START) begin
      busy_nxt      = 1'b1;
      kill_done_nxt = 1'b0;
      nas_to_nxt    = 1'b0;
      stor_ok_nxt   = 1'b0;
      retry_nxt     = 1'b0;
      snap_nxt      = '0;
      if (cfg_i.vault_present) begin
        snap_nxt = (item_i.snap_count_in > SNAP_SLOTS) ? SNAP_SLOTS : item_i.snap_count_in;
      end
      creq = 1'b1;
      if (!item_i.armed) begin
        phase_nxt = PH_DONE;
      end else begin
        phase_nxt   = PH_NAS;
        nas_due_nxt = item_i.now_sec + cfg_i.nas_timeout_sec;
        nreq        = cfg_i.transport_present;
      end
    end else if (busy_r && item_i.armed) begin
      unique case (phase_r)
        PH_NAS: begin
          if (cfg_i.transport_present && item_i.nas_acked) begin
            nas_to_nxt = 1'b0;
            leave_nas  = 1'b1;
          end else if (item_i.now_sec >= nas_due_r) begin
            nas_to_nxt = 1'b1;
            leave_nas  = 1'b1;
          end
        end
        PH_STORE: begin
          if (item_i.now_sec >= stor_due_r) begin
            sreq        = cfg_i.vault_present;
            stor_ok_nxt = cfg_i.vault_present && item_i.flush_ok;
            if (cfg_i.vault_present && item_i.flush_ok) begin
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt    = PH_RETRY;
              stor_due_nxt = stor_due_new;
            end
          end
        end
        PH_RETRY: begin
          if (item_i.now_sec >= stor_due_r) begin
            sreq = cfg_i.vault_present;
            if (cfg_i.vault_present) begin
              stor_ok_nxt = item_i.flush_ok;
            end
            retry_nxt = 1'b1;
            phase_nxt = PH_DONE;
          end
        end
        default: begin
        end
      endcase

      // Leaving the NAS wait: kill when snapshots exist and transport is present, always conceal
      if (leave_nas) begin
        if ((snap_r != '0) && cfg_i.transport_present) begin
          kreq          = 1'b1;
          kill_done_nxt = item_i.kill_accepted;
        end
        creq         = 1'b1;
        stor_due_nxt = stor_due_new;
        phase_nxt    = PH_STORE;
      end
    end
  end

  // Result for the current item
  always_comb begin
    res_o.phase             = phase_nxt;
    res_o.busy_res          = busy_nxt;
    res_o.kill_done         = kill_done_nxt;
    res_o.nas_timeout_flag  = nas_to_nxt;
    res_o.storage_ok        = stor_ok_nxt;
    res_o.retry_used        = retry_nxt;
    res_o.peek_ok           = (phase_nxt == PH_STORE) || (phase_nxt == PH_RETRY) ||
                              (phase_nxt == PH_DONE);
    res_o.snap_count_out    = snap_nxt;
    res_o.nas_flush_req     = nreq;
    res_o.kill_req          = kreq;
    res_o.conceal_req       = creq;
    res_o.storage_flush_req = sreq;
  end

  // State registers, updated on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      busy_r      <= 1'b0;
      kill_done_r <= 1'b0;
      nas_to_r    <= 1'b0;
      stor_ok_r   <= 1'b0;
      retry_r     <= 1'b0;
      snap_r      <= '0;
      nas_due_r   <= '0;
      stor_due_r  <= '0;
    end else if (accept_i) begin
      phase_r     <= phase_nxt;
      busy_r      <= busy_nxt;
      kill_done_r <= kill_done_nxt;
      nas_to_r    <= nas_to_nxt;
      stor_ok_r   <= stor_ok_nxt;
      retry_r     <= retry_nxt;
      snap_r      <= snap_nxt;
      nas_due_r   <= nas_due_nxt;
      stor_due_r  <= stor_due_nxt;
    end
  end

  // A start always leaves the sequencer busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept_i && (item_i.action == ACT_START) |=> busy_r)
    else $error("busy not set after start");

  // A kill request only comes with the move to storage wait and a conceal
  a_kill_store: assert property (@(posedge clk) disable iff (!rst_n)
    res_o.kill_req |-> (res_o.phase == PH_STORE) && res_o.conceal_req)
    else $error("kill request outside NAS exit");

  // State only moves on a transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept_i |=> $stable(phase_r) && $stable(stor_due_r))
    else $error("state changed without a transfer");

  // Retry flag only set once the sequence is done
  a_retry_done: assert property (@(posedge clk) disable iff (!rst_n)
    retry_r |-> (phase_r == PH_DONE))
    else $error("retry flag set before done");

endmodule

// ===== hdl/shutdown_sequencer_with_timeouts_unit.sv =====
// ----------------------------------------------------------------------------
// shutdown_sequencer_with_timeouts_unit: shutdown sequencer top level
// A result is registered in out_d_r, or in skid_d_r while out_* is stalled.
// Throughput: one item per cycle while the skid is empty; a two-entry output
// stage (register plus skid) keeps in_tready high for one stalled result.
// Reset: synchronous active-low rst_n; idle phase, flags cleared, timeout 5 s,
// storage delay 2 s, no partners attached, output stage empty.
// ----------------------------------------------------------------------------
module shutdown_sequencer_with_timeouts_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata: now_sec[31:0], armed[32], snap_count_in[37:33], nas_acked[38],
  //        kill_accepted[39], flush_ok[40], zero pad[47:41]
  input  logic [ssto_pkg::IN_DATA_W-1:0]      in_tdata,
  // tuser: action[0]
  input  logic                                in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // tdata: phase[2:0], busy_res[3], kill_done[4], nas_timeout_flag[5],
  //        storage_ok[6], retry_used[7], peek_ok[8], snap_count_out[13:9],
  //        nas_flush_req[14], kill_req[15], conceal_req[16],
  //        storage_flush_req[17], zero pad[23:18]
  output logic [ssto_pkg::OUT_DATA_W-1:0]     out_tdata,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [ssto_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssto_pkg::TIME_W-1:0]         cfg_wdata
);
  import ssto_pkg::*;

  cfg_t     cfg_r;
  in_item_t item;
  res_t     res;
  logic     accept;

  res_t     out_d_r, out_d_nxt;
  res_t     skid_d_r, skid_d_nxt;
  logic     out_v_r, out_v_nxt;
  logic     skid_v_r, skid_v_nxt;

  // Unpack the input transfer
  always_comb begin
    item.action        = in_tuser;
    item.now_sec       = in_tdata[31:0];
    item.armed         = in_tdata[32];
    item.snap_count_in = in_tdata[37:33];
    item.nas_acked     = in_tdata[38];
    item.kill_accepted = in_tdata[39];
    item.flush_ok      = in_tdata[40];
  end

  assign in_tready = !skid_v_r;
  assign accept    = in_tvalid && in_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nas_timeout_sec   <= TIME_W'(5);
      cfg_r.storage_delay_sec <= TIME_W'(2);
      cfg_r.transport_present <= 1'b0;
      cfg_r.vault_present     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NAS_TIMEOUT:   cfg_r.nas_timeout_sec   <= cfg_wdata;
        REG_STORAGE_DELAY: cfg_r.storage_delay_sec <= cfg_wdata;
        REG_TRANSPORT:     cfg_r.transport_present <= cfg_wdata[0];
        REG_VAULT:         cfg_r.vault_present     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  ssto_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (accept),
    .item_i   (item),
    .cfg_i    (cfg_r),
    .res_o    (res)
  );

  // Output register with skid stage
  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = accept;
        if (accept) begin
          out_d_nxt = res;
        end
      end
    end else if (accept) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  // Pack the result transfer
  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0,
                       out_d_r.storage_flush_req,
                       out_d_r.conceal_req,
                       out_d_r.kill_req,
                       out_d_r.nas_flush_req,
                       out_d_r.snap_count_out,
                       out_d_r.peek_ok,
                       out_d_r.retry_used,
                       out_d_r.storage_ok,
                       out_d_r.nas_timeout_flag,
                       out_d_r.kill_done,
                       out_d_r.busy_res,
                       out_d_r.phase};

  // Skid entry only ever sits behind a full output register
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds data while output register is empty");

  // A stalled result with a new transfer fills the skid stage
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready && accept |=> skid_v_r)
    else $error("result lost on stall");

  // After each transfer the output register holds a valid result next cycle
  a_accept_valid: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_v_r)
    else $error("no result after input transfer");

endmodule

// ===== bench/ssto_checker.sv =====
// ----------------------------------------------------------------------------
// ssto_checker: result checker for the shutdown sequencer
// Watches the input, result and configuration ports, runs its own model of
// the sequence on every input transfer and compares each result transfer,
// field by field, with the oldest predicted status.
// ----------------------------------------------------------------------------
module ssto_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [ssto_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [ssto_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [ssto_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssto_pkg::TIME_W-1:0]     cfg_wdata,
  output int                              fail_count,
  output int                              outstanding
);
  import ssto_pkg::*;

  // Configuration copy
  logic [TIME_W-1:0]  nas_wait_cfg;
  logic [TIME_W-1:0]  store_delay_cfg;
  logic               transport_cfg;
  logic               vault_cfg;

  // Sequencer state copy
  logic [PHASE_W-1:0] phase_q;
  logic               busy_q;
  logic               kill_done_q;
  logic               nas_to_q;
  logic               store_ok_q;
  logic               retry_q;
  logic [SNAP_W-1:0]  snap_q;
  logic [TIME_W-1:0]  nas_due_q;
  logic [TIME_W-1:0]  store_due_q;

  res_t status_q[$];
  int   errors = 0;
  int   n_waiting = 0;

  assign fail_count  = errors;
  assign outstanding = n_waiting;

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, predicted %0h", name, got, want));
  endtask

  // One input item through the sequence; returns the status it produces
  function automatic res_t step_sequencer(input in_item_t it);
    res_t r;
    r = '0;
    if (it.action == ACT_START) begin
      // start (or restart) clears flags and latches the snapshot count
      busy_q      = 1'b1;
      kill_done_q = 1'b0;
      nas_to_q    = 1'b0;
      store_ok_q  = 1'b0;
      retry_q     = 1'b0;
      snap_q      = '0;
      if (vault_cfg)
        snap_q = (it.snap_count_in > SNAP_SLOTS) ? SNAP_SLOTS : it.snap_count_in;
      r.conceal_req = 1'b1;
      if (!it.armed) begin
        phase_q = PH_DONE;
      end else begin
        phase_q         = PH_NAS;
        nas_due_q       = it.now_sec + nas_wait_cfg;
        r.nas_flush_req = transport_cfg;
      end
    end else if (busy_q && it.armed) begin
      unique case (phase_q)
        PH_NAS: begin
          // acknowledge (only with transport) or timeout ends the NAS wait
          if ((transport_cfg && it.nas_acked) || it.now_sec >= nas_due_q) begin
            nas_to_q = !(transport_cfg && it.nas_acked);
            if (snap_q != '0 && transport_cfg) begin
              r.kill_req  = 1'b1;
              kill_done_q = it.kill_accepted;
            end
            r.conceal_req = 1'b1;
            store_due_q   = it.now_sec + store_delay_cfg;
            phase_q       = PH_STORE;
          end
        end
        PH_STORE: begin
          if (it.now_sec >= store_due_q) begin
            r.storage_flush_req = vault_cfg;
            store_ok_q          = vault_cfg && it.flush_ok;
            if (store_ok_q) begin
              phase_q = PH_DONE;
            end else begin
              phase_q     = PH_RETRY;
              store_due_q = it.now_sec + store_delay_cfg;
            end
          end
        end
        PH_RETRY: begin
          if (it.now_sec >= store_due_q) begin
            r.storage_flush_req = vault_cfg;
            if (vault_cfg) store_ok_q = it.flush_ok;
            retry_q = 1'b1;
            phase_q = PH_DONE;
          end
        end
        default: ;
      endcase
    end
    r.phase            = phase_q;
    r.busy_res         = busy_q;
    r.kill_done        = kill_done_q;
    r.nas_timeout_flag = nas_to_q;
    r.storage_ok       = store_ok_q;
    r.retry_used       = retry_q;
    r.peek_ok          = (phase_q == PH_STORE || phase_q == PH_RETRY || phase_q == PH_DONE);
    r.snap_count_out   = snap_q;
    return r;
  endfunction

  // Port monitor: result pop first, so a result never meets its own item
  always @(posedge clk) begin
    in_item_t it;
    res_t     want;
    if (!rst_n) begin
      nas_wait_cfg    = 32'd5;
      store_delay_cfg = 32'd2;
      transport_cfg   = 1'b0;
      vault_cfg       = 1'b0;
      phase_q         = PH_IDLE;
      busy_q          = 1'b0;
      kill_done_q     = 1'b0;
      nas_to_q        = 1'b0;
      store_ok_q      = 1'b0;
      retry_q         = 1'b0;
      snap_q          = '0;
      nas_due_q       = '0;
      store_due_q     = '0;
      status_q.delete();
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NAS_TIMEOUT:   nas_wait_cfg    = cfg_wdata;
          REG_STORAGE_DELAY: store_delay_cfg = cfg_wdata;
          REG_TRANSPORT:     transport_cfg   = cfg_wdata[0];
          REG_VAULT:         vault_cfg       = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (status_q.size() == 0) begin
          report_mismatch($sformatf("result %0h with no item outstanding", out_tdata));
        end else begin
          want = status_q.pop_front();
          check_field("phase",             out_tdata[2:0],  want.phase);
          check_field("busy_res",          out_tdata[3],    want.busy_res);
          check_field("kill_done",         out_tdata[4],    want.kill_done);
          check_field("nas_timeout_flag",  out_tdata[5],    want.nas_timeout_flag);
          check_field("storage_ok",        out_tdata[6],    want.storage_ok);
          check_field("retry_used",        out_tdata[7],    want.retry_used);
          check_field("peek_ok",           out_tdata[8],    want.peek_ok);
          check_field("snap_count_out",    out_tdata[13:9], want.snap_count_out);
          check_field("nas_flush_req",     out_tdata[14],   want.nas_flush_req);
          check_field("kill_req",          out_tdata[15],   want.kill_req);
          check_field("conceal_req",       out_tdata[16],   want.conceal_req);
          check_field("storage_flush_req", out_tdata[17],   want.storage_flush_req);
        end
      end
      if (in_tvalid && in_tready) begin
        it.action        = in_tuser;
        it.now_sec       = in_tdata[31:0];
        it.armed         = in_tdata[32];
        it.snap_count_in = in_tdata[37:33];
        it.nas_acked     = in_tdata[38];
        it.kill_accepted = in_tdata[39];
        it.flush_ok      = in_tdata[40];
        status_q.push_back(step_sequencer(it));
      end
    end
    n_waiting = status_q.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for shutdown_sequencer_with_timeouts_unit
// Directed shutdown sequences, then random start/tick sequences under several
// register settings, with random gaps and stalls on both streams but the last.
// The checker predicts and compares; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import ssto_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 115;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [TIME_W-1:0]     cfg_wdata = '0;

  int          fail_count;
  int          outstanding;
  int          items_sent = 0;
  int          cycle_cnt = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  logic [31:0] sec_now = '0;

  shutdown_sequencer_with_timeouts_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ssto_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  // Result side: random stall bursts while enabled
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(1, 18) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic in_item_t mk_item(input logic act, input logic [31:0] t,
                                       input logic arm, input logic [4:0] snap,
                                       input logic ack, input logic kacc,
                                       input logic fok);
    in_item_t it;
    it.action        = act;
    it.now_sec       = t;
    it.armed         = arm;
    it.snap_count_in = snap;
    it.nas_acked     = ack;
    it.kill_accepted = kacc;
    it.flush_ok      = fok;
    return it;
  endfunction

  // Mostly legal counts, some above the slot limit to hit saturation
  function automatic logic [4:0] rand_snap();
    if ($urandom_range(0, 3) == 0) return 5'($urandom_range(17, 31));
    return 5'($urandom_range(0, 16));
  endfunction

  // One input transfer, with an optional gap before it
  task automatic send_item(input in_item_t it);
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.action;
    in_tdata  <= {7'b0, it.flush_ok, it.kill_accepted, it.nas_acked,
                  it.snap_count_in, it.armed, it.now_sec};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Sender holds off until every predicted status has been seen
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  // Start followed by a run of ticks with random partner replies
  task automatic run_sequence();
    int n_ticks;
    n_ticks = $urandom_range(2, 14);
    sec_now += $urandom_range(0, 3);
    send_item(mk_item(ACT_START, sec_now, $urandom_range(0, 4) != 0, rand_snap(),
                      $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1)));
    for (int k = 0; k < n_ticks; k++) begin
      if ($urandom_range(0, 19) == 0) sec_now = $urandom();
      else sec_now += $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) begin
        // noise: anything at all
        send_item(mk_item($urandom_range(0, 1), $urandom(), $urandom_range(0, 1),
                          5'($urandom_range(0, 31)), $urandom_range(0, 1),
                          $urandom_range(0, 1), $urandom_range(0, 1)));
      end else begin
        send_item(mk_item(ACT_TICK, sec_now, $urandom_range(0, 9) != 0, rand_snap(),
                          $urandom_range(0, 3) == 0, $urandom_range(0, 1),
                          $urandom_range(0, 1)));
      end
    end
  endtask

  // Stimulus
  initial begin
    logic [31:0] t_nas, t_dly;
    logic        t_tr, t_va;
    int          target;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: no partners, timeout 5, delay 2
    send_item(mk_item(ACT_TICK,  32'd0,         1'b1, 5'd3,  1'b1, 1'b1, 1'b1)); // not started
    send_item(mk_item(ACT_START, 32'd1,         1'b0, 5'd5,  1'b0, 1'b0, 1'b0)); // disarmed
    send_item(mk_item(ACT_TICK,  32'd9,         1'b1, 5'd0,  1'b0, 1'b0, 1'b0)); // in done
    send_item(mk_item(ACT_START, 32'hFFFF_FFFF, 1'b1, 5'd31, 1'b0, 1'b0, 1'b0)); // due wraps
    send_item(mk_item(ACT_TICK,  32'd0,         1'b1, 5'd0,  1'b1, 1'b1, 1'b0)); // ack, no link
    send_item(mk_item(ACT_TICK,  32'd10,        1'b0, 5'd0,  1'b0, 1'b0, 1'b0)); // disarmed
    send_item(mk_item(ACT_TICK,  32'd4,         1'b1, 5'd0,  1'b0, 1'b1, 1'b0)); // timeout
    send_item(mk_item(ACT_TICK,  32'd6,         1'b1, 5'd0,  1'b0, 1'b0, 1'b1)); // no vault
    send_item(mk_item(ACT_TICK,  32'd8,         1'b1, 5'd0,  1'b0, 1'b0, 1'b1)); // retry

    // both partners, zero waits
    wait_idle();
    repeat (2) @(negedge clk);
    write_reg(REG_NAS_TIMEOUT, 32'd0);
    write_reg(REG_STORAGE_DELAY, 32'd0);
    write_reg(REG_TRANSPORT, 32'd1);
    write_reg(REG_VAULT, 32'd1);
    cfg_we <= 1'b0;
    send_item(mk_item(ACT_START, 32'd100, 1'b1, 5'd31, 1'b0, 1'b0, 1'b0)); // saturates
    send_item(mk_item(ACT_TICK,  32'd90,  1'b1, 5'd0,  1'b1, 1'b1, 1'b0)); // ack + kill
    send_item(mk_item(ACT_TICK,  32'd90,  1'b1, 5'd0,  1'b0, 1'b0, 1'b0)); // flush fails
    send_item(mk_item(ACT_START, 32'd91,  1'b1, 5'd16, 1'b0, 1'b0, 1'b0)); // restart
    send_item(mk_item(ACT_TICK,  32'd91,  1'b1, 5'd0,  1'b0, 1'b0, 1'b0)); // timeout
    send_item(mk_item(ACT_TICK,  32'd92,  1'b1, 5'd0,  1'b0, 1'b0, 1'b1)); // flush ok
    send_item(mk_item(ACT_TICK,  32'd93,  1'b1, 5'd0,  1'b1, 1'b1, 1'b1)); // in done
    send_item(mk_item(ACT_START, 32'd94,  1'b1, 5'd0,  1'b0, 1'b0, 1'b0)); // no snapshots
    send_item(mk_item(ACT_TICK,  32'd94,  1'b1, 5'd0,  1'b1, 1'b1, 1'b0)); // kill not asked
    send_item(mk_item(ACT_TICK,  32'd95,  1'b1, 5'd0,  1'b0, 1'b0, 1'b0)); // to retry
    send_item(mk_item(ACT_TICK,  32'd95,  1'b1, 5'd0,  1'b0, 1'b0, 1'b1)); // retry ok

    // random sequences under a set of register settings
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      repeat (2) @(negedge clk);
      case (ph)
        0: begin t_nas = 32'd5; t_dly = 32'd2; t_tr = 1'b0; t_va = 1'b0; sec_now = 32'd100; end
        1: begin t_nas = 32'd0; t_dly = 32'd0; t_tr = 1'b1; t_va = 1'b1; sec_now = 32'hFFFF_FFF0; end
        2: begin t_nas = 32'd3; t_dly = 32'd1; t_tr = 1'b1; t_va = 1'b0; sec_now = 32'h8000_0000; end
        3: begin
          t_nas = 32'hFFFF_FFFF; t_dly = 32'hFFFF_FFFF; t_tr = 1'b1; t_va = 1'b1; sec_now = 32'd0;
        end
        4: begin t_nas = 32'd1; t_dly = 32'd3; t_tr = 1'b0; t_va = 1'b1; sec_now = 32'hFFFF_FF00; end
        default: begin
          t_nas = 32'd4; t_dly = 32'd2; t_tr = 1'b1; t_va = 1'b1; sec_now = 32'h1234_5678;
        end
      endcase
      write_reg(REG_NAS_TIMEOUT, t_nas);
      write_reg(REG_STORAGE_DELAY, t_dly);
      write_reg(REG_TRANSPORT, {31'b0, t_tr});
      write_reg(REG_VAULT, {31'b0, t_va});
      cfg_we <= 1'b0;
      // last setting runs with no gaps and no stalls
      tx_idle_on = (ph != 5);
      rx_idle_on = (ph != 5);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) run_sequence();
    end

    wait_idle();
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
